// File: rtl/core/tsr_pkg.sv
// Traffic slot replacement: shared types and constants.
// Slot entry layout, action codes and register reset values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsr_pkg;

    localparam int ID_W    = 24;
    localparam int TIME_W  = 32;
    localparam int DIST_W  = 16;
    localparam int ALARM_W = 2;
    localparam int EXP_W   = 8;
    localparam int CFG_W   = 16;

    localparam logic [DIST_W-1:0] ZONE_RESET   = 16'd15000;
    localparam logic [EXP_W-1:0]  EXPIRY_RESET = 8'd5;
    localparam int                MERGE_WINDOW = 3;

    typedef enum logic {
        CFG_ZONE   = 1'b0,
        CFG_EXPIRY = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ACT_OUT_OF_ZONE = 4'd0,
        ACT_NO_ROOM     = 4'd1,
        ACT_IGNORED     = 4'd2,
        ACT_MERGED      = 4'd3,
        ACT_SAME_ID     = 4'd4,
        ACT_EMPTY       = 4'd5,
        ACT_EXPIRED     = 4'd6,
        ACT_LOWER_ALARM = 4'd7,
        ACT_FARTHEST    = 4'd8
    } t_action;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TIME_W-1:0]  rtime;
        logic [DIST_W-1:0]  dist_m;
        logic [ALARM_W-1:0] alarm;
        logic               kind;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// File: rtl/core/traffic_slot_replacement.sv
// Traffic slot replacement: top level, slot table held in tsr_ram.
// Depends on tsr_pkg and tsr_ram.
// ST_SCAN reads each slot via the RAM read port, one entry per cycle, ST_WAIT
// takes the last word and ST_DECIDE writes the chosen slot and registers the
// result; dropped words (out of zone, zero id) skip the scan. A new word is
// taken after ST_DECIDE. A pending result does not block the next input.
// Reset (synchronous, active low) empties every slot via its valid bit and
// restores zone_limit 15000 and expiry_seconds 5; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module traffic_slot_replacement #(
    parameter int TABLE_SLOTS = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [tsr_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [tsr_pkg::ID_W-1:0]      i_object_id,
    input  wire logic [tsr_pkg::TIME_W-1:0]    i_report_time,
    input  wire logic [tsr_pkg::TIME_W-1:0]    i_own_time,
    input  wire logic [tsr_pkg::DIST_W-1:0]    i_distance,
    input  wire logic [tsr_pkg::ALARM_W-1:0]   i_alarm_level,
    input  wire logic                          i_packet_kind,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [2:0]                         o_slot,
    output tsr_pkg::t_action                   o_action
);

    import tsr_pkg::*;

    localparam int IW = $clog2(TABLE_SLOTS);
    localparam int XW = (IW > 3) ? IW : 3;
    localparam logic [IW-1:0] LAST_IX = IW'(TABLE_SLOTS - 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_WAIT   = 4'b0100,
        ST_DECIDE = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [DIST_W-1:0]  r_zone;
    logic [EXP_W-1:0]   r_expiry;

    logic [ID_W-1:0]    r_id;
    logic [TIME_W-1:0]  r_rt;
    logic [TIME_W-1:0]  r_own;
    logic [DIST_W-1:0]  r_dist;
    logic [ALARM_W-1:0] r_alarm;
    logic               r_kind;
    logic               r_drop;
    t_action            r_drop_act;

    logic [IW-1:0]      r_rd_ix;
    logic               r_ev;
    logic [IW-1:0]      r_ev_ix;
    logic [TABLE_SLOTS-1:0] r_valid;

    logic               r_match_found;
    logic [IW-1:0]      r_match_ix;
    logic [TIME_W-1:0]  r_match_time;
    logic               r_match_kind;
    logic               r_int_le3;
    logic               r_int_pos;

    logic               r_free_found;
    logic [IW-1:0]      r_free_ix;
    t_action            r_free_act;

    logic [IW-1:0]      r_far_ix;
    logic [DIST_W-1:0]  r_far_dist;
    logic [ALARM_W-1:0] r_far_alarm;
    logic [IW-1:0]      r_low_ix;
    logic [ALARM_W-1:0] r_low_alarm;

    logic               r_out_valid;
    logic [2:0]         r_out_slot;
    t_action            r_out_action;

    logic [ENTRY_W-1:0] ram_rdata;
    logic               ram_we;
    t_entry             ev_entry;
    logic               ev_valid;
    logic signed [TIME_W:0] ev_diff;
    logic [TIME_W:0]    ev_exp_sum;
    logic               ev_match;
    logic               ev_free;
    logic               ev_expired;

    logic               accept;
    logic               can_load;
    logic               dec_we;
    logic [IW-1:0]      dec_ix;
    t_entry             dec_entry;
    t_entry             new_entry;
    logic               dec_hit;
    t_action            dec_act;
    logic [XW-1:0]      dec_slot_ext;

    assign o_ready  = (r_state == ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign can_load = !r_out_valid || i_ready;
    assign o_valid  = r_out_valid;
    assign o_slot   = r_out_slot;
    assign o_action = r_out_action;

    tsr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (dec_ix),
        .i_wdata (dec_entry),
        .i_raddr (r_rd_ix),
        .o_rdata (ram_rdata)
    );

    // per-entry evaluation of the word returned by the RAM
    always_comb begin
        ev_entry   = t_entry'(ram_rdata);
        ev_valid   = r_valid[r_ev_ix];
        ev_diff    = $signed({1'b0, r_rt}) - $signed({1'b0, ev_entry.rtime});
        ev_exp_sum = {1'b0, ev_entry.rtime} + (TIME_W + 1)'(r_expiry);
        ev_match   = ev_valid && (ev_entry.id == r_id);
        ev_expired = ev_valid && ({1'b0, r_own} > ev_exp_sum);
        ev_free    = !ev_valid || ev_expired;
    end

    // final decision over the collected scan results
    always_comb begin
        new_entry = '{id: r_id, rtime: r_rt, dist_m: r_dist, alarm: r_alarm, kind: r_kind};
        dec_entry = new_entry;
        dec_we    = 1'b0;
        dec_ix    = '0;
        dec_hit   = 1'b0;
        dec_act   = ACT_NO_ROOM;
        if (r_drop) begin
            dec_act = r_drop_act;
        end else if (r_match_found) begin
            dec_ix  = r_match_ix;
            dec_hit = 1'b1;
            if (r_kind && r_int_le3 && !r_match_kind) begin
                if (r_int_pos) begin
                    dec_we          = 1'b1;
                    dec_entry.rtime = r_match_time;
                    dec_entry.kind  = r_match_kind;
                    dec_act         = ACT_MERGED;
                end else begin
                    dec_act = ACT_IGNORED;
                end
            end else begin
                dec_we  = 1'b1;
                dec_act = ACT_SAME_ID;
            end
        end else if (r_free_found) begin
            dec_we  = 1'b1;
            dec_ix  = r_free_ix;
            dec_hit = 1'b1;
            dec_act = r_free_act;
        end else if (r_alarm > r_low_alarm) begin
            dec_we  = 1'b1;
            dec_ix  = r_low_ix;
            dec_hit = 1'b1;
            dec_act = ACT_LOWER_ALARM;
        end else if ((r_dist < r_far_dist) && (r_alarm >= r_far_alarm)) begin
            dec_we  = 1'b1;
            dec_ix  = r_far_ix;
            dec_hit = 1'b1;
            dec_act = ACT_FARTHEST;
        end
        dec_slot_ext = dec_hit ? XW'(dec_ix) : '0;
    end

    assign ram_we = (r_state == ST_DECIDE) && can_load && dec_we;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ((i_distance > r_zone) || (i_object_id == '0)) ?
                              ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_rd_ix == LAST_IX) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (can_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_zone      <= ZONE_RESET;
            r_expiry    <= EXPIRY_RESET;
            r_valid     <= '0;
            r_ev        <= 1'b0;
            r_out_valid <= 1'b0;
            r_rd_ix     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ZONE:   r_zone   <= i_cfg_wdata;
                    CFG_EXPIRY: r_expiry <= i_cfg_wdata[EXP_W-1:0];
                    default:    r_zone   <= r_zone;
                endcase
            end

            // advance the read pointer one entry per cycle
            r_ev    <= (r_state == ST_SCAN);
            r_ev_ix <= r_rd_ix;
            if (accept) begin
                r_rd_ix <= '0;
            end else if (r_state == ST_SCAN && r_rd_ix != LAST_IX) begin
                r_rd_ix <= IW'(r_rd_ix + 1'b1);
            end

            if (ram_we) begin
                r_valid[dec_ix] <= 1'b1;
            end

            if (r_state == ST_DECIDE && can_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_id          <= i_object_id;
            r_rt          <= i_report_time;
            r_own         <= i_own_time;
            r_dist        <= i_distance;
            r_alarm       <= i_alarm_level;
            r_kind        <= i_packet_kind;
            r_drop        <= (i_distance > r_zone) || (i_object_id == '0);
            r_drop_act    <= (i_distance > r_zone) ? ACT_OUT_OF_ZONE : ACT_NO_ROOM;
            r_match_found <= 1'b0;
            r_free_found  <= 1'b0;
        end

        if (r_ev) begin
            if (ev_match && !r_match_found) begin
                r_match_found <= 1'b1;
                r_match_ix    <= r_ev_ix;
                r_match_time  <= ev_entry.rtime;
                r_match_kind  <= ev_entry.kind;
                r_int_le3     <= (ev_diff <= (TIME_W + 1)'(MERGE_WINDOW));
                r_int_pos     <= (ev_diff > 0);
            end
            if (ev_free && !r_free_found) begin
                r_free_found <= 1'b1;
                r_free_ix    <= r_ev_ix;
                r_free_act   <= ev_valid ? ACT_EXPIRED : ACT_EMPTY;
            end
            if (r_ev_ix == '0) begin
                r_far_ix    <= '0;
                r_far_dist  <= ev_entry.dist_m;
                r_far_alarm <= ev_entry.alarm;
                r_low_ix    <= '0;
                r_low_alarm <= ev_entry.alarm;
            end else begin
                if (ev_entry.dist_m > r_far_dist) begin
                    r_far_ix    <= r_ev_ix;
                    r_far_dist  <= ev_entry.dist_m;
                    r_far_alarm <= ev_entry.alarm;
                end
                if (ev_entry.alarm < r_low_alarm) begin
                    r_low_ix    <= r_ev_ix;
                    r_low_alarm <= ev_entry.alarm;
                end
            end
        end

        if (r_state == ST_DECIDE && can_load) begin
            r_out_slot   <= dec_slot_ext[2:0];
            r_out_action <= dec_act;
        end
    end

    a_write_in_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_DECIDE))
        else $error("slot write outside decision cycle");

    a_no_zero_id_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (dec_entry.id != '0))
        else $error("slot written with zero id");

    a_scan_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |=> (r_state == ST_SCAN) || (r_state == ST_WAIT))
        else $error("scan left early");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DECIDE))
        else $error("result raised outside decision");

    a_match_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) && r_drop |-> (dec_we == 1'b0))
        else $error("dropped word wrote a slot");

endmodule

`default_nettype wire

// File: rtl/core/tsr_ram.sv
// Traffic slot replacement: generic single-port-write, single-port-read RAM.
// Registered read. No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module tsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
